>>> design/ifc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instant fuel consumption filter package
// Shared types and constants for the filter controller and datapath.
// ----------------------------------------------------------------------------
package ifc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_MAX_DIST = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_HOUR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MOVING = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STOPPED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_DIV = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RPM_FLOOR = 3'd5;

  localparam logic [15:0] TurnOnReading = 16'd200;
  localparam int unsigned DivW = 32;

  typedef struct packed {
    logic        ignition_on;
    logic [15:0] odometer_cm;
    logic [15:0] fuel_amount;
    logic        fuel_ok;
    logic        speed_fault;
    logic [15:0] vehicle_speed;
    logic [13:0] engine_rpm;
    logic        rpm_ok;
  } in_item_t;

  typedef struct packed {
    logic [15:0] consumption;
    logic        unit_hourly;
    logic        reading_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_per_distance;
    logic [15:0] max_per_hour;
    logic [15:0] moving_speed;
    logic [15:0] stopped_speed;
    logic [15:0] idle_divisor;
    logic [13:0] rpm_floor;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture item, run front-end filter
    logic avg;       // take the averages, advance the smoothed value
    logic div_start; // start a divider run
    logic div_sel;
    logic finish;    // commit reading
  } dp_cmd_t;

  localparam logic DIV_DIST = 1'b0;
  localparam logic DIV_HOUR = 1'b1;

  typedef struct packed {
    logic div_done;
    logic ign;
    logic good;
    logic dist_mode;
    logic hour_mode;
  } dp_sts_t;

endpackage

>>> design/ifc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload of parameter type.
// ----------------------------------------------------------------------------
interface ifc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/ifc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, 32 by 32 bits.
// ----------------------------------------------------------------------------
module ifc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import ifc_pkg::*;

  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    trial = {rem_q[31:0], quot_q[31]};
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      cnt_d = 6'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    if (start_i) den_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> design/ifc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter datapath
// Histories, dropout filter, slew, hysteresis and clamps around a divider.
// ----------------------------------------------------------------------------
module ifc_datapath #(
  parameter int unsigned FUEL_TAPS = 5,
  parameter int unsigned DIST_TAPS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifc_pkg::cfg_t     cfg_i,
  input  ifc_pkg::in_item_t item_i,
  input  ifc_pkg::dp_cmd_t  cmd_i,
  output ifc_pkg::dp_sts_t  sts_o,
  output ifc_pkg::out_item_t res_o
);
  import ifc_pkg::*;

  localparam int unsigned FSumW = 16 + $clog2(FUEL_TAPS + 1);
  localparam int unsigned DSumW = 16 + $clog2(DIST_TAPS + 1);
  // reciprocal scaling, exact for every sum the histories can hold
  localparam int unsigned FShift = FSumW + 4;
  localparam int unsigned DShift = DSumW + 4;
  localparam int unsigned FProdW = FSumW + FShift;
  localparam int unsigned DProdW = DSumW + DShift;
  localparam logic [63:0] FMul =
    ((64'd1 << FShift) + 64'(FUEL_TAPS) - 64'd1) / 64'(FUEL_TAPS);
  localparam logic [63:0] DMul =
    ((64'd1 << DShift) + 64'(DIST_TAPS) - 64'd1) / 64'(DIST_TAPS);

  in_item_t    it_q;
  logic [15:0] prev_odo_q, prev_fuel_q, smooth_q, held_q, cur_q;
  logic        ign_seen_q, primed_q, drop_q, change_q, unit_q, valid_q;
  logic [15:0] fhist_q [FUEL_TAPS];
  logic [15:0] dhist_q [DIST_TAPS];
  logic [15:0] davg_q;

  logic [15:0] odo_delta, fuel_f, prev_fuel_n;
  logic        drop_n;
  logic [FSumW-1:0] fsum;
  logic [DSumW-1:0] dsum;
  logic [FProdW-1:0] fprod;
  logic [DProdW-1:0] dprod;
  logic [15:0] favg, davg;
  logic        good;
  logic [31:0] div_a, div_b, quot;
  logic        div_done;

  assign good = it_q.fuel_ok && !it_q.speed_fault;

  // distance delta and dropout filter on the incoming item
  always_comb begin
    if (item_i.odometer_cm >= prev_odo_q) odo_delta = item_i.odometer_cm - prev_odo_q;
    else odo_delta = item_i.odometer_cm - prev_odo_q - 16'd1;
    fuel_f = item_i.fuel_amount;
    drop_n = drop_q;
    prev_fuel_n = prev_fuel_q;
    if (item_i.fuel_amount == 16'd0 && prev_fuel_q != 16'd0 && !drop_q) begin
      fuel_f = prev_fuel_q;
      drop_n = 1'b1;
    end else begin
      if (drop_q) begin
        drop_n = 1'b0;
        if (item_i.fuel_amount > prev_fuel_q) fuel_f = item_i.fuel_amount - prev_fuel_q;
        else if (item_i.fuel_amount > 16'd0) fuel_f = item_i.fuel_amount - 16'd1;
      end
      prev_fuel_n = fuel_f;
    end
  end

  // history sums
  always_comb begin
    fsum = '0;
    for (int i = 0; i < FUEL_TAPS; i++) fsum = fsum + FSumW'(fhist_q[i]);
    dsum = '0;
    for (int i = 0; i < DIST_TAPS; i++) dsum = dsum + DSumW'(dhist_q[i]);
  end

  // averages by reciprocal multiplication
  assign fprod = FProdW'(fsum) * FProdW'(FMul);
  assign dprod = DProdW'(dsum) * DProdW'(DMul);
  assign favg = fprod[FShift +: 16];
  assign davg = dprod[DShift +: 16];

  // divider operand selection
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_DIST: begin div_a = 32'(smooth_q) * 32'd1000; div_b = 32'(davg_q); end
      default:  begin div_a = 32'(smooth_q) * 32'd36; div_b = 32'(cfg_i.idle_divisor); end
    endcase
  end

  ifc_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quot_o(quot)
  );

  // slew of smoothed value toward favg
  function automatic logic [15:0] slew(logic [15:0] last, logic [15:0] avg);
    logic [15:0] gap;
    begin
      gap = '0;
      slew = last;
      if (last > avg) begin
        gap = (last - avg) >> 2;
        if (avg == 16'd0) slew = '0;
        else slew = (gap == 16'd0) ? last - 16'd1 : last - gap;
      end else if (last < avg) begin
        gap = (avg - last) >> 2;
        slew = (gap == 16'd0) ? last + 16'd1 : last + gap;
      end
    end
  endfunction

  // final reading
  logic [15:0] r_sat, r, hd, cur_n, held_n, dmag;
  logic        change_n, unit_n, valid_n;
  logic [31:0] rounded;
  logic [39:0] tenth_prod;
  always_comb begin
    rounded = quot + 32'd5;
    // divide by ten; exact for every operand below 2^20
    tenth_prod = 40'(rounded[19:0]) * 40'd838861;
    r_sat = '0;
    r = '0;
    dmag = '0;
    cur_n = cur_q;
    held_n = held_q;
    change_n = change_q;
    unit_n = unit_q;
    valid_n = valid_q;
    hd = cur_q;
    if (!good) begin
      cur_n = held_q;
      valid_n = 1'b0;
    end else if (sts_o.dist_mode) begin
      // the /10 of the rounded quotient: quot holds the raw quotient here
      if (davg_q != 16'd0) r_sat = (quot > 32'd655345) ? 16'hFFFF
                                   : tenth_prod[38:23];
      else if (smooth_q > 16'd1) r_sat = cfg_i.max_per_distance;
      else r_sat = '0;
      r = r_sat;
      held_n = hd;
      dmag = (r > hd) ? r - hd : hd - r;
      if (dmag > 16'd1) begin
        held_n = r;
        change_n = 1'b1;
      end else if (!change_q) r = hd;
      else change_n = 1'b0;
      if (r > cfg_i.max_per_distance) r = cfg_i.max_per_distance;
      cur_n = r;
      unit_n = 1'b0;
      valid_n = 1'b1;
    end else if (sts_o.hour_mode) begin
      if (cfg_i.idle_divisor == 16'd0) r_sat = 16'hFFFF;
      else r_sat = (quot > 32'h0000FFFF) ? 16'hFFFF : quot[15:0];
      cur_n = (r_sat > cfg_i.max_per_hour) ? cfg_i.max_per_hour : r_sat;
      unit_n = 1'b1;
      valid_n = 1'b1;
    end
    if (it_q.engine_rpm <= cfg_i.rpm_floor || !it_q.rpm_ok) cur_n = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_odo_q <= '0; prev_fuel_q <= '0; smooth_q <= '0; held_q <= '0;
      cur_q <= '0; ign_seen_q <= 1'b0; primed_q <= 1'b0; drop_q <= 1'b0;
      change_q <= 1'b0; unit_q <= 1'b0; valid_q <= 1'b0;
      davg_q <= '0;
      for (int i = 0; i < FUEL_TAPS; i++) fhist_q[i] <= '0;
      for (int i = 0; i < DIST_TAPS; i++) dhist_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        if (!item_i.ignition_on) ign_seen_q <= 1'b0;
        else begin
          if (!ign_seen_q) begin
            ign_seen_q <= 1'b1;
            cur_q <= TurnOnReading;
          end
          prev_odo_q <= item_i.odometer_cm;
          if (item_i.fuel_ok && !item_i.speed_fault) begin
            drop_q <= drop_n;
            prev_fuel_q <= prev_fuel_n;
            primed_q <= 1'b1;
            // shift histories, priming fills all taps first
            for (int i = 1; i < FUEL_TAPS; i++)
              fhist_q[i] <= primed_q ? fhist_q[i-1] : fuel_f;
            fhist_q[0] <= fuel_f;
            for (int i = 1; i < DIST_TAPS; i++)
              dhist_q[i] <= primed_q ? dhist_q[i-1] : odo_delta;
            dhist_q[0] <= odo_delta;
          end
        end
      end
      if (cmd_i.avg) begin
        smooth_q <= slew(smooth_q, favg);
        davg_q <= davg;
      end
      if (cmd_i.finish) begin
        cur_q <= cur_n; held_q <= held_n; change_q <= change_n;
        unit_q <= unit_n; valid_q <= valid_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.ign = it_q.ignition_on;
  assign sts_o.good = good;
  assign sts_o.dist_mode = it_q.vehicle_speed >= cfg_i.moving_speed;
  assign sts_o.hour_mode = it_q.vehicle_speed < cfg_i.stopped_speed;
  assign res_o.consumption = cur_q;
  assign res_o.unit_hourly = unit_q;
  assign res_o.reading_valid = valid_q;
endmodule

>>> design/ifc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter controller
// Sequences capture, the averaging step, the reading division and output.
// ----------------------------------------------------------------------------
module ifc_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ifc_pkg::dp_sts_t sts_i,
  output ifc_pkg::dp_cmd_t cmd_o
);
  import ifc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       sel_q, sel_d;
  logic       started_q, started_d;

  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    started_d = 1'b0;
    cmd_o = '0;
    cmd_o.div_sel = sel_q;
    in_ready_o = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = S_AVG;
      end
      S_AVG: begin
        // drop ignition-off ticks, skip the filter on invalid samples
        if (!sts_i.ign) state_d = S_IDLE;
        else if (!sts_i.good) state_d = S_FIN;
        else begin
          cmd_o.avg = 1'b1;
          state_d = S_READ;
          sel_d = sts_i.dist_mode ? DIV_DIST : DIV_HOUR;
        end
      end
      S_READ: begin
        // launch then wait for the division
        if (!started_q) begin
          cmd_o.div_start = 1'b1; started_d = 1'b1;
        end else if (sts_i.div_done) state_d = S_FIN;
        else started_d = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q <= DIV_DIST;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      started_q <= started_d;
    end
  end
endmodule

>>> design/instant_fuel_consumption_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instant fuel consumption filter
// Per-tick fuel smoothing with L/100km or L/h reading.
// ----------------------------------------------------------------------------
// Usage: one tick item enters on in_ch; one reading leaves on out_ch for each
// tick with the ignition on, none for ticks with it off. Configuration is to be
// written on cfg_we_i / cfg_idx_i / cfg_data_i by the user only while the block
// is idle; the block itself does not enforce this. One item at a time: an
// ignition-off tick frees the input after the averaging state; an invalid
// sample shows its reading after the averaging and finish states; a normal
// tick shows its reading after the averaging step, one pass through the 32-bit
// serial divider and the finish state. The input is ready again in the cycle
// after the reading transfer. The result sits in the output register until
// taken; a stalled receiver holds the block and the next tick waits on
// in_ch. Reset restores filter, control and configuration defaults and
// clears histories.
// ----------------------------------------------------------------------------
module instant_fuel_consumption_filter #(
  parameter int unsigned FUEL_TAPS = 5,
  parameter int unsigned DIST_TAPS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ifc_stream_if.sink                     in_ch,
  ifc_stream_if.source                   out_ch,
  input  logic                           cfg_we_i,
  input  logic [ifc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ifc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ifc_pkg::*;

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  out_item_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_per_distance <= 16'd300;
      cfg_q.max_per_hour <= 16'd300;
      cfg_q.moving_speed <= 16'd5;
      cfg_q.stopped_speed <= 16'd3;
      cfg_q.idle_divisor <= 16'd2000;
      cfg_q.rpm_floor <= 14'd170;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_DIST:  cfg_q.max_per_distance <= cfg_data_i;
        REG_MAX_HOUR:  cfg_q.max_per_hour <= cfg_data_i;
        REG_MOVING:    cfg_q.moving_speed <= cfg_data_i;
        REG_STOPPED:   cfg_q.stopped_speed <= cfg_data_i;
        REG_IDLE_DIV:  cfg_q.idle_divisor <= cfg_data_i;
        REG_RPM_FLOOR: cfg_q.rpm_floor <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  ifc_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ifc_datapath #(.FUEL_TAPS(FUEL_TAPS), .DIST_TAPS(DIST_TAPS)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .item_i(in_ch.data),
    .cmd_i(cmd), .sts_o(sts), .res_o(res)
  );

  assign out_ch.data = res;
endmodule

>>> tb/sv/instant_fuel_consumption_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instant fuel consumption filter checker
// Watches the tick and reading channels and the register write port. Keeps
// its own model of the filter state, predicts one reading per ignition-on
// tick and compares every reading transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module instant_fuel_consumption_filter_checker
  import ifc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_valid_i,
  input  logic                tick_ready_i,
  input  in_item_t            tick_data_i,
  input  logic                reading_valid_i,
  input  logic                reading_ready_i,
  input  out_item_t           reading_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  localparam int FuelTaps = 5;
  localparam int DistTaps = 2;

  cfg_t        regs;
  logic [15:0] last_odo;
  logic        ign_seen;
  logic        primed;
  logic [15:0] fuel_hist [FuelTaps];
  logic [15:0] dist_hist [DistTaps];
  logic [15:0] last_fuel;
  logic        in_dropout;
  logic [15:0] smooth_fuel;
  logic [15:0] held;
  logic        changed;
  logic [15:0] reading;
  logic        unit_hour;
  logic        valid_flag;
  out_item_t   reading_q [$];

  // Move a quarter of the way to the average, at least 1; to 0 on a zero average
  function automatic logic [15:0] slew_towards(logic [15:0] last, logic [31:0] avg);
    logic [31:0] gap;
    if (last > avg) begin
      gap = (last - avg) / 4;
      if (avg == 0) return 16'd0;
      return (gap == 0) ? last - 16'd1 : last - gap[15:0];
    end
    if (last < avg) begin
      gap = (avg - last) / 4;
      return (gap == 0) ? last + 16'd1 : last + gap[15:0];
    end
    return last;
  endfunction

  // Advance the filter by one tick; returns 1 when a reading is produced
  function automatic bit predict_reading(in_item_t t, output out_item_t r);
    logic [15:0] odo_delta;
    logic [15:0] fuel;
    logic [31:0] fsum;
    logic [31:0] dsum;
    logic [31:0] favg;
    logic [31:0] davg;
    logic [31:0] q;
    logic [31:0] cons;
    logic [15:0] rd;
    logic [15:0] diff;
    r = '0;
    if (!t.ignition_on) begin
      ign_seen = 1'b0;
      return 1'b0;
    end
    if (!ign_seen) begin
      ign_seen = 1'b1;
      reading  = TurnOnReading;
    end
    // odometer wrap: a backward step loses one more count
    if (t.odometer_cm >= last_odo) odo_delta = t.odometer_cm - last_odo;
    else odo_delta = t.odometer_cm - last_odo - 16'd1;
    last_odo = t.odometer_cm;
    fuel = t.fuel_amount;

    if (t.fuel_ok && !t.speed_fault) begin
      // cover a single zero dropout with the previous sample
      if (fuel == 0 && last_fuel != 0 && !in_dropout) begin
        fuel = last_fuel;
        in_dropout = 1'b1;
      end else begin
        if (in_dropout) begin
          in_dropout = 1'b0;
          if (fuel > last_fuel) fuel = fuel - last_fuel;
          else if (fuel > 0) fuel = fuel - 16'd1;
        end
        last_fuel = fuel;
      end
      if (!primed) begin
        primed = 1'b1;
        for (int i = 0; i < FuelTaps; i++) fuel_hist[i] = fuel;
        for (int i = 0; i < DistTaps; i++) dist_hist[i] = odo_delta;
      end
      fsum = 0;
      for (int i = FuelTaps - 1; i >= 1; i--) fuel_hist[i] = fuel_hist[i-1];
      fuel_hist[0] = fuel;
      for (int i = 0; i < FuelTaps; i++) fsum += fuel_hist[i];
      favg = fsum / FuelTaps;
      smooth_fuel = slew_towards(smooth_fuel, favg);
      dsum = 0;
      for (int i = DistTaps - 1; i >= 1; i--) dist_hist[i] = dist_hist[i-1];
      dist_hist[0] = odo_delta;
      for (int i = 0; i < DistTaps; i++) dsum += dist_hist[i];
      davg = dsum / DistTaps;

      if ({16'd0, t.vehicle_speed} >= regs.moving_speed) begin
        held = reading;
        if (davg > 0) begin
          q  = (smooth_fuel * 32'd1000 / davg + 32'd5) / 32'd10;
          rd = (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
        end else if (smooth_fuel > 1) begin
          rd = regs.max_per_distance;
        end else begin
          rd = 16'd0;
        end
        // hysteresis of one count
        diff = (rd > held) ? rd - held : held - rd;
        if (diff > 1) begin
          held    = rd;
          changed = 1'b1;
        end else if (!changed) begin
          rd = held;
        end else begin
          changed = 1'b0;
        end
        if (rd > regs.max_per_distance) rd = regs.max_per_distance;
        reading    = rd;
        unit_hour  = 1'b0;
        valid_flag = 1'b1;
      end else if (t.vehicle_speed < regs.stopped_speed) begin
        if (regs.idle_divisor == 0) cons = 32'hFFFF;
        else cons = smooth_fuel * 32'd36 / regs.idle_divisor;
        if (cons > regs.max_per_hour) cons = regs.max_per_hour;
        reading    = (cons > 32'hFFFF) ? 16'hFFFF : cons[15:0];
        unit_hour  = 1'b1;
        valid_flag = 1'b1;
      end
    end else begin
      reading    = held;
      valid_flag = 1'b0;
    end
    if (t.engine_rpm <= regs.rpm_floor || !t.rpm_ok) reading = 16'd0;
    r.consumption   = reading;
    r.unit_hourly   = unit_hour;
    r.reading_valid = valid_flag;
    return 1'b1;
  endfunction

  // Predict on tick transfers, compare on reading transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_rd;
    out_item_t got;
    if (!rst_ni) begin
      regs        = '{16'd300, 16'd300, 16'd5, 16'd3, 16'd2000, 14'd170};
      last_odo    = '0;
      ign_seen    = 1'b0;
      primed      = 1'b0;
      for (int i = 0; i < FuelTaps; i++) fuel_hist[i] = '0;
      for (int i = 0; i < DistTaps; i++) dist_hist[i] = '0;
      last_fuel   = '0;
      in_dropout  = 1'b0;
      smooth_fuel = '0;
      held        = '0;
      changed     = 1'b0;
      reading     = '0;
      unit_hour   = 1'b0;
      valid_flag  = 1'b0;
      reading_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_DIST:  regs.max_per_distance = cfg_data_i;
          REG_MAX_HOUR:  regs.max_per_hour     = cfg_data_i;
          REG_MOVING:    regs.moving_speed     = cfg_data_i;
          REG_STOPPED:   regs.stopped_speed    = cfg_data_i;
          REG_IDLE_DIV:  regs.idle_divisor     = cfg_data_i;
          REG_RPM_FLOOR: regs.rpm_floor        = cfg_data_i[13:0];
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        if (predict_reading(tick_data_i, exp_rd)) reading_q.push_back(exp_rd);
      end
      if (reading_valid_i && reading_ready_i) begin
        got = reading_data_i;
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected reading %0d unit %0b valid %0b", $time,
                   got.consumption, got.unit_hourly, got.reading_valid);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_rd = reading_q.pop_front();
          if (got !== exp_rd) begin
            $display("%0t: reading mismatch: expected %0d/%0b/%0b actual %0d/%0b/%0b",
                     $time, exp_rd.consumption, exp_rd.unit_hourly,
                     exp_rd.reading_valid, got.consumption, got.unit_hourly,
                     got.reading_valid);
            fail_count_o <= fail_count_o + 1;
          end
          checked_o <= checked_o + 1;
        end
      end
      outstanding_o <= reading_q.size();
    end
  end

endmodule

>>> tb/sv/instant_fuel_consumption_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instant fuel consumption filter testbench
// Drives directed and random ticks through several register settings with
// random idling on both channels, a long reading stall and a drain pause;
// the checker beside the block predicts and compares every reading.
// ----------------------------------------------------------------------------
module instant_fuel_consumption_filter_tb;
  import ifc_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  outstanding;
  int                  checked;
  int                  snd_idle;
  int                  rcv_idle;
  int                  stall_left;
  int                  ticks_sent;
  logic [15:0]         odo_now;
  cfg_t                cur_cfg;

  ifc_stream_if #(.payload_t(in_item_t))  in_ch ();
  ifc_stream_if #(.payload_t(out_item_t)) out_ch ();

  instant_fuel_consumption_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  instant_fuel_consumption_filter_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_valid_i    (in_ch.valid),
    .tick_ready_i    (in_ch.ready),
    .tick_data_i     (in_ch.data),
    .reading_valid_i (out_ch.valid),
    .reading_ready_i (out_ch.ready),
    .reading_data_i  (out_ch.data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .checked_o       (checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Guard against a hung handshake
  initial begin
    #50_000_000;
    $display("instant_fuel_consumption_filter_tb failed");
    $finish;
  end

  // Reading side: random idling, plus a long stall on request
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   = stall_left - 1;
      end else begin
        out_ch.ready <= ($urandom % 100) >= rcv_idle;
      end
    end
  end

  function automatic in_item_t mk_tick(logic ign, logic [15:0] odo, logic [15:0] fuel,
                                       logic fok, logic sfault, logic [15:0] spd,
                                       logic [13:0] rpm, logic rok);
    in_item_t t;
    t.ignition_on   = ign;
    t.odometer_cm   = odo;
    t.fuel_amount   = fuel;
    t.fuel_ok       = fok;
    t.speed_fault   = sfault;
    t.vehicle_speed = spd;
    t.engine_rpm    = rpm;
    t.rpm_ok        = rok;
    return t;
  endfunction

  // Offer one tick and hold it until transferred; starts and ends at a falling edge
  task automatic send_tick(in_item_t t);
    while (($urandom % 100) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every reading, let the block settle, then reprogram
  task automatic program_regs(cfg_t c);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    cur_cfg = c;
    cfg_we <= 1'b1; cfg_idx <= REG_MAX_DIST;  cfg_data <= c.max_per_distance;
    @(negedge clk_i);
    cfg_idx <= REG_MAX_HOUR;  cfg_data <= c.max_per_hour;
    @(negedge clk_i);
    cfg_idx <= REG_MOVING;    cfg_data <= c.moving_speed;
    @(negedge clk_i);
    cfg_idx <= REG_STOPPED;   cfg_data <= c.stopped_speed;
    @(negedge clk_i);
    cfg_idx <= REG_IDLE_DIV;  cfg_data <= c.idle_divisor;
    @(negedge clk_i);
    cfg_idx <= REG_RPM_FLOOR; cfg_data <= {2'b00, c.rpm_floor};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly plausible drive cycles around the thresholds, some raw noise
  function automatic in_item_t random_tick();
    in_item_t t;
    int       spd;
    int       rpm;
    if (($urandom % 100) < 8) begin
      t = mk_tick(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom), 14'($urandom), 1'($urandom));
      return t;
    end
    odo_now = 16'(odo_now + $urandom_range(0, 60));
    case ($urandom % 4)
      0: spd = cur_cfg.moving_speed + $urandom_range(0, 100);
      1: spd = (cur_cfg.stopped_speed == 0) ? 0 : $urandom_range(0, cur_cfg.stopped_speed - 1);
      2: spd = $urandom_range(cur_cfg.stopped_speed, cur_cfg.moving_speed);
      default: spd = $urandom_range(0, 65535);
    endcase
    if (spd > 65535) spd = 65535;
    rpm = (($urandom % 10) == 0) ? $urandom_range(0, cur_cfg.rpm_floor)
                                 : cur_cfg.rpm_floor + $urandom_range(1, 3000);
    if (rpm > 16383) rpm = 16383;
    t = mk_tick(($urandom % 40) != 0, odo_now,
                (($urandom % 10) == 0) ? 16'd0 : 16'($urandom_range(0, 3000)),
                ($urandom % 20) != 0, ($urandom % 25) == 0, 16'(spd), 14'(rpm),
                ($urandom % 20) != 0);
    return t;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      send_tick(random_tick());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_MAX_DIST;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    snd_idle    = 29;
    rcv_idle    = 60;
    ticks_sent  = 0;
    odo_now     = '0;
    cur_cfg     = '{16'd300, 16'd300, 16'd5, 16'd3, 16'd2000, 14'd170};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed ticks at reset settings
    send_tick(mk_tick(0, 16'd0,     16'd0,     1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd100,   16'd400,   1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd150,   16'd400,   1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd150,   16'd0,     1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd150,   16'd0,     1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd200,   16'd500,   1, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd260,   16'd0,     1, 0, 16'd2,     14'd800,   1));
    send_tick(mk_tick(1, 16'd300,   16'd700,   1, 0, 16'd0,     14'd800,   1));
    send_tick(mk_tick(1, 16'd310,   16'd600,   0, 0, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd320,   16'd600,   1, 1, 16'd10,    14'd800,   1));
    send_tick(mk_tick(1, 16'd330,   16'd600,   1, 0, 16'd4,     14'd800,   1));
    send_tick(mk_tick(1, 16'd331,   16'd600,   1, 0, 16'd3,     14'd800,   1));
    send_tick(mk_tick(1, 16'd332,   16'd600,   1, 0, 16'd5,     14'd800,   1));
    send_tick(mk_tick(1, 16'd10,    16'd600,   1, 0, 16'd30,    14'd800,   1));
    for (int i = 0; i < 4; i++)
      send_tick(mk_tick(1, 16'(16'd11 + i), 16'hFFFF, 1, 0, 16'd30, 14'd800, 1));
    send_tick(mk_tick(1, 16'd20,    16'd900,   1, 0, 16'd30,    14'd170,   1));
    send_tick(mk_tick(1, 16'd21,    16'd900,   1, 0, 16'd30,    14'd171,   1));
    send_tick(mk_tick(1, 16'd22,    16'd900,   1, 0, 16'd30,    14'd3000,  0));
    send_tick(mk_tick(1, 16'hFFFF,  16'd900,   1, 0, 16'hFFFF,  14'h3FFF,  1));
    send_tick(mk_tick(0, 16'hFFFF,  16'd900,   1, 0, 16'd30,    14'd800,   1));
    send_tick(mk_tick(1, 16'd5,     16'd900,   1, 0, 16'd30,    14'd800,   1));
    odo_now = 16'd5;

    // Typical settings, sender idles less than receiver
    program_regs('{16'd250, 16'd150, 16'd8, 16'd4, 16'd1800, 14'd400});
    run_random(600);

    // Wide-open clamps, distance mode at any speed
    snd_idle = 60;
    rcv_idle = 29;
    program_regs('{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1, 14'd0});
    run_random(150);

    // Hourly mode at every speed below 65535, zero divisor saturates
    program_regs('{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 14'd0});
    run_random(150);

    // Tightest clamps and highest rpm floor
    program_regs('{16'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 14'h3FFF});
    run_random(50);

    // Back to reset values; long reading stall, then a full drain
    program_regs('{16'd300, 16'd300, 16'd5, 16'd3, 16'd2000, 14'd170});
    run_random(200);
    stall_left = 600;
    run_random(200);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    run_random(200);

    // Random settings, no idling
    snd_idle = 0;
    rcv_idle = 0;
    program_regs('{16'($urandom), 16'($urandom), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 200)), 16'($urandom_range(1, 65535)),
                   14'($urandom_range(0, 2000))});
    run_random(300);

    // Drain and settle
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);

    $display("Sent %0d ticks over seven register settings; %0d readings compared.",
             ticks_sent, checked);
    $display("Covered dropouts, invalid samples, mode thresholds, clamps and stalls.");
    if (fail_count == 0) begin
      $display("instant_fuel_consumption_filter_tb passed");
    end else begin
      $display("instant_fuel_consumption_filter_tb failed");
    end
    $finish;
  end

endmodule
